// ===== hw/rtl/vmss_pkg.sv =====
`default_nettype none

package vmss_pkg;

    localparam int DIGIT_POSITIONS = 4;
    localparam int SAMPLE_BITS     = 10;

    localparam int DIGIT_W  = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;
    localparam int PHASE_W  = 3;
    localparam int FS_W     = 14;
    localparam int FRAMES_W = 8;
    localparam int MV_W     = FS_W;
    localparam int SEL_W    = 3;
    localparam int SEG_W    = 8;

    // v / 10 == (v * 52429) >> 19 for every v below 43690
    localparam int DIV10_W     = 16;
    localparam int DIV10_SHIFT = 19;
    localparam logic [DIV10_W-1:0] DIV10_MUL = 16'd52429;

    localparam logic [FS_W-1:0]     FS_RESET     = 14'd3300;
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 8'd64;
    localparam logic [SEL_W-1:0]    SEL_STATUS   = 3'd4;
    localparam logic [SEG_W-1:0]    SEG_ALL_OFF  = 8'hff;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic REG_FULL_SCALE = 1'b0;
    localparam logic REG_FRAMES     = 1'b1;

    typedef logic [3:0] digit_t;
    typedef digit_t [DIGIT_POSITIONS-1:0] digits_t;

    typedef struct packed {
        logic             sample_request;
        logic             output_off;
        logic [SEG_W-1:0] segments;
        logic [SEL_W-1:0] position_select;
    } scan_view_t;

    // active-low patterns; codes above nine light everything
    function automatic logic [SEG_W-1:0] seg_pattern(input digit_t d);
        logic [SEG_W-1:0] p;
        case (d)
            4'd0:    p = ~8'h3f;
            4'd1:    p = ~8'h06;
            4'd2:    p = ~8'h5b;
            4'd3:    p = ~8'h4f;
            4'd4:    p = ~8'h66;
            4'd5:    p = ~8'h6d;
            4'd6:    p = ~8'h7d;
            4'd7:    p = ~8'h07;
            4'd8:    p = ~8'h7f;
            4'd9:    p = ~8'h6f;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    function automatic logic [SEL_W-1:0] pos_code(input logic [DIGIT_W-1:0] i);
        logic [SEL_W-1:0] c;
        case (i)
            2'd0:    c = 3'd3;
            2'd1:    c = 3'd0;
            2'd2:    c = 3'd1;
            default: c = 3'd2;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vmss_conv.sv =====
`default_nettype none

module vmss_conv
    import vmss_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [FS_W-1:0]        full_scale,
    output logic                        busy,
    output digits_t                     digits
);

    logic                           busy_reg, busy_next;
    logic [DIGIT_W-1:0]             cnt_reg, cnt_next;
    logic [MV_W-1:0]                val_reg, val_next;
    digits_t                        digits_reg, digits_next;

    logic [SAMPLE_BITS+FS_W-1:0]    prod;
    logic [MV_W+DIV10_W-1:0]        recip;
    logic [MV_W-1:0]                quot;
    logic [MV_W-1:0]                rem;
    logic [DIGIT_W-1:0]             widx;

    assign prod  = sample * full_scale;
    assign recip = val_reg * DIV10_MUL;
    assign quot  = MV_W'(recip >> DIV10_SHIFT);
    assign rem   = val_reg - ((quot << 3) + (quot << 1));
    assign widx  = DIGIT_W'(DIGIT_POSITIONS - 1) - cnt_reg;

    always_comb begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        digits_next = digits_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = prod[SAMPLE_BITS +: MV_W];
        end else if (busy_reg) begin
            // least significant digit first
            digits_next[widx] = rem[3:0];
            val_next          = quot;
            cnt_next          = cnt_reg + 1'b1;
            if (cnt_reg == DIGIT_W'(DIGIT_POSITIONS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            for (int i = 0; i < DIGIT_POSITIONS; i++) begin
                digits_reg[i] <= digit_t'(i + 1);
            end
        end else begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            digits_reg <= digits_next;
        end
        val_reg <= val_next;
    end

    assign busy   = busy_reg;
    assign digits = digits_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("conversion started while busy");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && cnt_reg == '0)
        else $error("conversion did not begin after start");

    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == DIGIT_W'(DIGIT_POSITIONS - 1) |=> !busy_reg)
        else $error("conversion ran past last digit");

endmodule

`default_nettype wire

// ===== hw/rtl/vmss_scan.sv =====
`default_nettype none

module vmss_scan
    import vmss_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                beat,
    input  wire logic                command,
    input  wire logic [FRAMES_W-1:0] frames,
    input  wire digits_t             digits,
    output logic                     start,
    output scan_view_t               view_next
);

    logic                   reading_reg, reading_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [FRAMES_W-1:0]    frame_reg, frame_next;
    logic [SEL_W-1:0]       sel_reg, sel_next;
    logic [SEG_W-1:0]       seg_reg, seg_next;
    logic                   off_reg, off_next;
    logic                   tick;
    logic [DIGIT_W-1:0]     pidx;

    assign start = beat && reading_reg && (command == CMD_SAMPLE);
    assign tick  = beat && !reading_reg && (command == CMD_TICK);
    assign pidx  = phase_reg[DIGIT_W-1:0];

    always_comb begin
        reading_next = reading_reg;
        phase_next   = phase_reg;
        frame_next   = frame_reg;
        sel_next     = sel_reg;
        seg_next     = seg_reg;
        off_next     = off_reg;
        if (start) begin
            reading_next = 1'b0;
            phase_next   = '0;
            frame_next   = '0;
        end else if (tick) begin
            off_next = 1'b1;
            if (phase_reg < PHASE_W'(DIGIT_POSITIONS)) begin
                sel_next   = pos_code(pidx);
                seg_next   = seg_pattern(digits[pidx]);
                off_next   = 1'b0;
                phase_next = phase_reg + 1'b1;
            end else begin
                // blank phase closes the frame; select and segments hold
                phase_next = '0;
                frame_next = frame_reg + 1'b1;
                if (frame_next >= frames) begin
                    reading_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reading_reg <= 1'b1;
            phase_reg   <= '0;
            frame_reg   <= '0;
            sel_reg     <= SEL_STATUS;
            seg_reg     <= SEG_ALL_OFF;
            off_reg     <= 1'b1;
        end else begin
            reading_reg <= reading_next;
            phase_reg   <= phase_next;
            frame_reg   <= frame_next;
            sel_reg     <= sel_next;
            seg_reg     <= seg_next;
            off_reg     <= off_next;
        end
    end

    always_comb begin
        view_next.position_select = sel_next;
        view_next.segments        = seg_next;
        view_next.output_off      = off_next;
        view_next.sample_request  = reading_next;
    end

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PHASE_W'(DIGIT_POSITIONS))
        else $error("scan phase out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/adc_voltmeter_seven_segment_scan.sv =====
`default_nettype none

// Voltmeter display scanner. Each input beat carries a command in s_tuser
// (0 = ADC sample, 1 = timer tick) and a 10-bit sample in s_tdata; each input
// beat yields exactly one output beat showing the display state after it:
// decoder code, active-low segments, drive disable and sample request. In
// reading mode a sample is scaled to millivolts, floor(sample * full scale /
// 1024), and split into four decimal digits; ticks then scan digit positions
// plus one blanking phase per frame until the programmed frame count is done.
// Rate: one beat per cycle while s_tready is high. A sample that starts a
// reading holds s_tready low after its beat, while the digit unit peels off
// one decimal digit per cycle (one multiply by the reciprocal of ten per
// step). Output is registered; input keeps flowing while a result waits,
// as long as the output register drains in the same cycle. Registers:
// index 0 full-scale millivolts (14 bit, reset 3300), index 1 frames per
// reading (8 bit, reset 64, 0 acts as 1). Write them only while idle.

module adc_voltmeter_seven_segment_scan
    import vmss_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [9:0] sample
    input  wire logic [0:0]  s_tuser,   // [0] command

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [2:0] position_select, [10:3] segments,
                                        // [11] output_off, [12] sample_request

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [13:0] cfg_data
);

    logic [FS_W-1:0]     fs_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic                m_valid_reg;
    scan_view_t          m_view_reg;

    logic                s_beat;
    logic                out_free;
    logic                conv_busy;
    logic                start;
    digits_t             digits;
    scan_view_t          view_next;

    // output slot is free when empty or being drained this cycle
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = out_free && !conv_busy;
    assign s_beat    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg     <= FS_RESET;
            frames_reg <= FRAMES_RESET;
        end else if (cfg_valid) begin
            case (cfg_index[0])
                REG_FULL_SCALE: fs_reg     <= cfg_data[FS_W-1:0];
                REG_FRAMES:     frames_reg <= cfg_data[FRAMES_W-1:0];
                default:        ;
            endcase
        end
    end

    vmss_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat      (s_beat),
        .command   (s_tuser[0]),
        .frames    (frames_reg),
        .digits    (digits),
        .start     (start),
        .view_next (view_next)
    );

    vmss_conv u_conv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .sample     (s_tdata[SAMPLE_BITS-1:0]),
        .full_scale (fs_reg),
        .busy       (conv_busy),
        .digits     (digits)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (s_beat) begin
            m_view_reg <= view_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_view_reg};

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_busy |-> !s_tready)
        else $error("input taken during digit conversion");

    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> m_valid_reg && !m_view_reg.sample_request)
        else $error("reading start not reflected in result");

endmodule

`default_nettype wire

// ===== dv/tb_adc_voltmeter_seven_segment_scan.sv =====
`default_nettype none

module tb_adc_voltmeter_seven_segment_scan;
    import vmss_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 12;
    localparam int CYCLE_LIMIT = 500000;  // many times the slowest legal run
    localparam int IDLE_CYC    = 8;       // covers the digit unit's busy stretch after a sample
    localparam int HOLD_CYC    = 300;     // long receiver back-pressure stretch
    localparam int NOISE_PCT   = 15;      // share of beats the block should ignore

    // Shadow of the display scanner: config, mode, digits, scan position and the
    // latched display outputs. Every accepted input beat queues one expected view.
    class scan_view_predictor;
        logic [FS_W-1:0]     full_scale;
        logic [FRAMES_W-1:0] frames;
        logic                reading;
        digit_t              digits [DIGIT_POSITIONS];
        logic [PHASE_W-1:0]  phase;
        logic [FRAMES_W-1:0] frame_cnt;
        scan_view_t          view;
        scan_view_t          expected_views [$];
        int                  errors;

        function new();
            full_scale = FS_RESET;
            frames     = FRAMES_RESET;
            reading    = 1'b1;
            for (int i = 0; i < DIGIT_POSITIONS; i++)
                digits[i] = digit_t'(i + 1);
            phase     = '0;
            frame_cnt = '0;
            view.position_select = SEL_STATUS;
            view.segments        = SEG_ALL_OFF;
            view.output_off      = 1'b1;
            view.sample_request  = 1'b1;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [FS_W-1:0] value);
            if (idx == REG_FULL_SCALE)
                full_scale = value;
            else
                frames = value[FRAMES_W-1:0];
        endfunction

        // active-low; anything above nine lights all segments
        function logic [SEG_W-1:0] lit(digit_t d);
            logic [SEG_W-1:0] on;
            case (d)
                4'd0:    on = 8'h3f;
                4'd1:    on = 8'h06;
                4'd2:    on = 8'h5b;
                4'd3:    on = 8'h4f;
                4'd4:    on = 8'h66;
                4'd5:    on = 8'h6d;
                4'd6:    on = 8'h7d;
                4'd7:    on = 8'h07;
                4'd8:    on = 8'h7f;
                4'd9:    on = 8'h6f;
                default: on = 8'hff;
            endcase
            return ~on;
        endfunction

        function void accept_input(logic cmd, logic [SAMPLE_BITS-1:0] smp);
            int unsigned         mv;
            logic [FRAMES_W-1:0] goal;
            if (reading && cmd == CMD_SAMPLE) begin
                mv = (32'(smp) * 32'(full_scale)) >> SAMPLE_BITS;
                // most significant digit in slot 0; higher digits drop off
                for (int p = DIGIT_POSITIONS - 1; p >= 0; p--) begin
                    digits[p] = digit_t'(mv % 10);
                    mv = mv / 10;
                end
                reading   = 1'b0;
                phase     = '0;
                frame_cnt = '0;
            end else if (!reading && cmd == CMD_TICK) begin
                view.output_off = 1'b1;   // blank phase keeps select and segments
                if (phase < DIGIT_POSITIONS) begin
                    // decoder wiring: digit 0..3 -> code 3,0,1,2
                    view.position_select = SEL_W'((phase + 3) % 4);
                    view.segments        = lit(digits[phase]);
                    view.output_off      = 1'b0;
                end
                phase++;
                if (phase > DIGIT_POSITIONS) begin
                    phase = '0;
                    frame_cnt++;
                    goal = (frames == '0) ? FRAMES_W'(1) : frames;
                    if (frame_cnt >= goal)
                        reading = 1'b1;
                end
            end
            view.sample_request = reading;
            expected_views.push_back(view);
        endfunction

        function void check_output(logic [15:0] beat);
            scan_view_t got;
            scan_view_t want;
            got = beat[12:0];
            if (expected_views.size() == 0) begin
                $error("unexpected output beat %h", beat);
                errors++;
                return;
            end
            want = expected_views.pop_front();
            if (got.position_select !== want.position_select) begin
                $error("position_select: expected %0d, actual %0d",
                       want.position_select, got.position_select);
                errors++;
            end
            if (got.segments !== want.segments) begin
                $error("segments: expected %h, actual %h", want.segments, got.segments);
                errors++;
            end
            if (got.output_off !== want.output_off) begin
                $error("output_off: expected %0d, actual %0d",
                       want.output_off, got.output_off);
                errors++;
            end
            if (got.sample_request !== want.sample_request) begin
                $error("sample_request: expected %0d, actual %0d",
                       want.sample_request, got.sample_request);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [9:0] sample
    logic [0:0]  s_tuser;     // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // [2:0] position_select, [10:3] segments,
                              // [11] output_off, [12] sample_request
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [13:0] cfg_data;

    scan_view_predictor display_model;

    int rx_stall_pct;   // receiver back-pressure, percent of cycles
    bit hold_req;       // one-shot request for a long receiver hold-off

    adc_voltmeter_seven_segment_scan dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // Receiver: random stalls per phase, plus a long hold-off on request so
    // the output register fills and s_tready drops while beats keep coming.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Output monitor: one check per accepted output beat, values sampled
    // before this edge's updates land.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            display_model.check_output(m_tdata);
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Mismatches found");
        $finish;
    end

    // One input beat: valid stays high on return so back-to-back beats need
    // no second assignment in the same step.
    task automatic send_beat(logic cmd, logic [SAMPLE_BITS-1:0] smp);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= 16'(smp);
        do @(posedge aclk); while (!s_tready);
        display_model.accept_input(cmd, smp);
    endtask

    task automatic write_reg(logic idx, logic [13:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        display_model.set_reg(idx, value);
        @(posedge aclk);
    endtask

    // Drop valid, wait for every expected view, then let the digit unit finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (display_model.expected_views.size() > 0) @(posedge aclk);
        repeat (IDLE_CYC) @(posedge aclk);
    endtask

    // Mostly well-formed traffic: samples while reading, ticks while
    // displaying; the rest is noise the block must ignore. Only beats that
    // change state count toward n.
    task automatic run_random(int n, int tx_idle_pct);
        int                     counted;
        logic                   cmd;
        logic [SAMPLE_BITS-1:0] smp;
        bit                     live;
        counted = 0;
        while (counted < n) begin
            if ($urandom_range(0, 99) < NOISE_PCT)
                cmd = display_model.reading ? CMD_TICK : CMD_SAMPLE;
            else
                cmd = display_model.reading ? CMD_SAMPLE : CMD_TICK;
            case ($urandom_range(0, 9))
                0:       smp = '0;
                1:       smp = '1;
                default: smp = SAMPLE_BITS'($urandom);
            endcase
            live = (cmd == CMD_SAMPLE) ? display_model.reading : !display_model.reading;
            if (live)
                counted++;
            if ($urandom_range(0, 99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
            end
            send_beat(cmd, smp);
        end
    endtask

    task automatic tick_frame();
        repeat (DIGIT_POSITIONS + 1) send_beat(CMD_TICK, '0);
    endtask

    initial begin
        display_model = new();
        rx_stall_pct  = 0;
        hold_req      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_SAMPLE;
        cfg_valid = 1'b0;
        cfg_index = REG_FULL_SCALE;
        cfg_data  = '0;

        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (IDLE_CYC) @(posedge aclk);

        // Directed, reset config: tick while reading is ignored, full-scale
        // sample, then a sample while displaying is ignored.
        send_beat(CMD_TICK, 10'h2aa);
        send_beat(CMD_SAMPLE, '1);
        send_beat(CMD_SAMPLE, 10'h155);
        tick_frame();
        settle();

        // Top of the four-digit range, one frame per reading; the frame count
        // is already at one, so the next frame ends the reading.
        write_reg(REG_FULL_SCALE, 14'd9999);
        write_reg(REG_FRAMES, 14'd1);
        tick_frame();
        send_beat(CMD_SAMPLE, '1);
        tick_frame();
        settle();

        // Register above 9999 keeps only the low four digits; frame count of
        // zero behaves like one.
        write_reg(REG_FULL_SCALE, '1);
        write_reg(REG_FRAMES, 14'd0);
        send_beat(CMD_SAMPLE, '1);
        tick_frame();
        settle();

        // Random phases: no idling, sender idle, receiver stall with long
        // hold-off, both idle, then the longest frame count.
        write_reg(REG_FULL_SCALE, FS_W'(FS_RESET));
        write_reg(REG_FRAMES, 14'd2);
        run_random(80, 0);
        settle();

        write_reg(REG_FULL_SCALE, 14'($urandom_range(1, 9999)));
        write_reg(REG_FRAMES, 14'd1);
        run_random(80, 53);
        settle();

        write_reg(REG_FULL_SCALE, 14'd1);
        write_reg(REG_FRAMES, 14'($urandom_range(0, 3)));
        rx_stall_pct = 53;
        hold_req     = 1'b1;
        run_random(80, 0);
        settle();

        write_reg(REG_FULL_SCALE, 14'($urandom));
        write_reg(REG_FRAMES, 14'($urandom_range(0, 3)));
        rx_stall_pct = 36;
        run_random(80, 36);
        settle();

        // 255 frames: one full reading is 1275 ticks, then a little more
        write_reg(REG_FULL_SCALE, 14'($urandom_range(1, 9999)));
        write_reg(REG_FRAMES, 14'd255);
        rx_stall_pct = 0;
        run_random(1290, 0);
        settle();

        if (display_model.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
